FILE: hdl/ftht_pkg.sv
package ftht_pkg;

  // table geometry (slot count must be a power of two)
  localparam int unsigned Slots = 1024;
  localparam int unsigned IdxW = $clog2(Slots);
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [CntW-1:0] FullLimit = CntW'((Slots * 3) / 4);
  localparam logic [CntW-1:0] SlotsCnt = CntW'(Slots);

  // FNV-1a style mixing constants
  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;

  // command codes
  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdLookup = 2'd1;
  localparam logic [1:0] CmdRemove = 2'd2;

  // status codes
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StDuplicate = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [31:0] dest_address;
    logic [15:0] dest_port;
  } cmd_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [IdxW-1:0] slot_index;
    logic [CntW-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] saddr;
    logic [15:0] sport;
    logic [31:0] daddr;
    logic [15:0] dport;
  } key_t;

  // one table slot as stored in the RAM
  typedef struct packed {
    logic            used;
    logic [IdxW-1:0] home;
    key_t            key;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_RH_RD,
    S_RH_CHK,
    S_RI_RD,
    S_RI_CHK,
    S_DONE
  } state_e;

endpackage

FILE: hdl/flow_tuple_hash_table_core.sv
// Connection table keyed by the TCP/IP 4-tuple, with linear probing over a
// slot RAM with one write port and one read port. Raise start_i with a
// command word on cmd_i while busy_o is low; the result word appears on
// rsp_o for exactly one cycle with done_o high and cannot be stalled, so the
// receiver must take it then. After reset the block clears every slot of
// the RAM (busy_o high). A command then hashes its four key fields in turn
// on the shared 32x32 multiplier and probes slots, each with a read state
// and a check state, before its result state. A remove that finds its key
// then reads each slot after the removed one, up to and including the
// first empty slot, and searches from its home for a new place for each
// entry that it moves. An insert at the full mark, an unused code, or a
// lookup or remove on an empty table goes straight to the result state.
// The block returns to idle after each result and only then takes the next
// command.
module flow_tuple_hash_table_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ftht_pkg::cmd_t cmd_i,
  output logic          busy_o,
  output logic          done_o,
  output ftht_pkg::rsp_t rsp_o
);

  localparam int unsigned IdxW = ftht_pkg::IdxW;
  localparam int unsigned CntW = ftht_pkg::CntW;

  ftht_pkg::state_e state_q, state_d;
  logic [1:0]            op_q, op_d;
  ftht_pkg::key_t        key_q, key_d;
  logic [31:0]           h_q, h_d;
  logic [1:0]            step_q, step_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [IdxW-1:0]       home_q, home_d;
  logic [CntW-1:0]       n_q, n_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [IdxW-1:0]       nxt_q, nxt_d;
  logic [CntW-1:0]       rhn_q, rhn_d;
  ftht_pkg::key_t        mk_q, mk_d;
  logic [IdxW-1:0]       mh_q, mh_d;
  logic [IdxW-1:0]       ri_q, ri_d;
  logic [1:0]            st_q, st_d;
  logic [IdxW-1:0]       slot_q, slot_d;
  logic [IdxW-1:0]       clr_q, clr_d;

  logic                  ram_we;
  logic [IdxW-1:0]       ram_waddr;
  ftht_pkg::slot_t       ram_wdata;
  logic [IdxW-1:0]       ram_raddr;
  logic [ftht_pkg::SlotW-1:0] ram_rdata;
  ftht_pkg::slot_t       rd;

  logic [31:0]           mix_in;
  logic [31:0]           mix_prod;
  logic                  key_hit;

  ftht_ram #(
    .Width(ftht_pkg::SlotW),
    .Depth(ftht_pkg::Slots)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd = ftht_pkg::slot_t'(ram_rdata);
  assign key_hit = (rd.key == key_q);

  // shared hash unit: one field per cycle
  always_comb begin
    case (step_q)
      2'd0:    mix_in = key_q.saddr;
      2'd1:    mix_in = {16'd0, key_q.sport};
      2'd2:    mix_in = key_q.daddr;
      default: mix_in = {16'd0, key_q.dport};
    endcase
    mix_prod = (h_q ^ mix_in) * ftht_pkg::FnvPrime;
  end

  // next state and datapath
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    key_d   = key_q;
    h_d     = h_q;
    step_d  = step_q;
    idx_d   = idx_q;
    home_d  = home_q;
    n_d     = n_q;
    cnt_d   = cnt_q;
    nxt_d   = nxt_q;
    rhn_d   = rhn_q;
    mk_d    = mk_q;
    mh_d    = mh_q;
    ri_d    = ri_q;
    st_d    = st_q;
    slot_d  = slot_q;
    clr_d   = clr_q;
    case (state_q)
      ftht_pkg::S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ftht_pkg::S_IDLE;
        end
      end
      ftht_pkg::S_IDLE: begin
        if (start_i) begin
          op_d   = cmd_i.command;
          key_d  = {cmd_i.source_address, cmd_i.source_port,
                    cmd_i.dest_address, cmd_i.dest_port};
          h_d    = ftht_pkg::FnvBasis;
          step_d = 2'd0;
          slot_d = '0;
          st_d   = ftht_pkg::StNotFound;
          if (cmd_i.command == ftht_pkg::CmdInsert) begin
            if (cnt_q >= ftht_pkg::FullLimit) begin
              st_d    = ftht_pkg::StFull;
              state_d = ftht_pkg::S_DONE;
            end else begin
              state_d = ftht_pkg::S_HASH;
            end
          end else if (cmd_i.command == ftht_pkg::CmdLookup ||
                       cmd_i.command == ftht_pkg::CmdRemove) begin
            state_d = (cnt_q == '0) ? ftht_pkg::S_DONE : ftht_pkg::S_HASH;
          end else begin
            state_d = ftht_pkg::S_DONE;
          end
        end
      end
      ftht_pkg::S_HASH: begin
        h_d    = mix_prod;
        step_d = step_q + 1'b1;
        if (step_q == 2'd3) begin
          home_d  = mix_prod[IdxW-1:0];
          idx_d   = mix_prod[IdxW-1:0];
          n_d     = '0;
          state_d = ftht_pkg::S_PROBE_RD;
        end
      end
      ftht_pkg::S_PROBE_RD: begin
        state_d = ftht_pkg::S_PROBE_CHK;
      end
      ftht_pkg::S_PROBE_CHK: begin
        if (!rd.used) begin
          if (op_q == ftht_pkg::CmdInsert) begin
            cnt_d  = cnt_q + 1'b1;
            st_d   = ftht_pkg::StOk;
            slot_d = idx_q;
          end
          state_d = ftht_pkg::S_DONE;
        end else if (key_hit) begin
          if (op_q == ftht_pkg::CmdInsert) begin
            st_d    = ftht_pkg::StDuplicate;
            state_d = ftht_pkg::S_DONE;
          end else if (op_q == ftht_pkg::CmdLookup) begin
            st_d    = ftht_pkg::StOk;
            slot_d  = idx_q;
            state_d = ftht_pkg::S_DONE;
          end else begin
            cnt_d   = cnt_q - 1'b1;
            st_d    = ftht_pkg::StOk;
            slot_d  = idx_q;
            nxt_d   = idx_q + 1'b1;
            rhn_d   = '0;
            state_d = ftht_pkg::S_RH_RD;
          end
        end else begin
          idx_d = idx_q + 1'b1;
          n_d   = n_q + 1'b1;
          if (n_q == ftht_pkg::SlotsCnt - 1'b1) begin
            if (op_q == ftht_pkg::CmdInsert) begin
              st_d = ftht_pkg::StFull;
            end
            state_d = ftht_pkg::S_DONE;
          end else begin
            state_d = ftht_pkg::S_PROBE_RD;
          end
        end
      end
      ftht_pkg::S_RH_RD: begin
        state_d = ftht_pkg::S_RH_CHK;
      end
      ftht_pkg::S_RH_CHK: begin
        if (!rd.used || rhn_q == ftht_pkg::SlotsCnt) begin
          state_d = ftht_pkg::S_DONE;
        end else begin
          mk_d    = rd.key;
          mh_d    = rd.home;
          ri_d    = rd.home;
          state_d = ftht_pkg::S_RI_RD;
        end
      end
      ftht_pkg::S_RI_RD: begin
        state_d = ftht_pkg::S_RI_CHK;
      end
      ftht_pkg::S_RI_CHK: begin
        if (rd.used) begin
          ri_d    = ri_q + 1'b1;
          state_d = ftht_pkg::S_RI_RD;
        end else begin
          nxt_d   = nxt_q + 1'b1;
          rhn_d   = rhn_q + 1'b1;
          state_d = ftht_pkg::S_RH_RD;
        end
      end
      ftht_pkg::S_DONE: begin
        state_d = ftht_pkg::S_IDLE;
      end
      default: begin
        state_d = ftht_pkg::S_IDLE;
      end
    endcase
  end

  // RAM port control and handshake outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '0;
    ram_raddr = idx_q;
    busy_o    = (state_q != ftht_pkg::S_IDLE);
    done_o    = (state_q == ftht_pkg::S_DONE);
    case (state_q)
      ftht_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      ftht_pkg::S_PROBE_CHK: begin
        if (!rd.used && op_q == ftht_pkg::CmdInsert) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b1, home_q, key_q};
        end else if (rd.used && key_hit && op_q == ftht_pkg::CmdRemove) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b0, rd.home, rd.key};
        end
      end
      ftht_pkg::S_RH_RD: begin
        ram_raddr = nxt_q;
      end
      ftht_pkg::S_RH_CHK: begin
        // lift the entry out before searching its new place
        if (rd.used && rhn_q != ftht_pkg::SlotsCnt) begin
          ram_we    = 1'b1;
          ram_waddr = nxt_q;
          ram_wdata = {1'b0, rd.home, rd.key};
        end
      end
      ftht_pkg::S_RI_RD: begin
        ram_raddr = ri_q;
      end
      ftht_pkg::S_RI_CHK: begin
        if (!rd.used) begin
          ram_we    = 1'b1;
          ram_waddr = ri_q;
          ram_wdata = {1'b1, mh_q, mk_q};
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign rsp_o = {st_q, slot_q, cnt_q};

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftht_pkg::S_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    h_q    <= h_d;
    step_q <= step_d;
    idx_q  <= idx_d;
    home_q <= home_d;
    n_q    <= n_d;
    nxt_q  <= nxt_d;
    rhn_q  <= rhn_d;
    mk_q   <= mk_d;
    mh_q   <= mh_d;
    ri_q   <= ri_d;
    st_q   <= st_d;
    slot_q <= slot_d;
  end

endmodule

FILE: hdl/ftht_ram.sv
module ftht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/flow_tuple_hash_table_core_test.sv
`timescale 1ns / 1ps

module flow_tuple_hash_table_core_test;

  localparam int unsigned RandWords = 1350;
  localparam int unsigned Slots = ftht_pkg::Slots;
  localparam int unsigned IdxW = ftht_pkg::IdxW;
  localparam int unsigned CntW = ftht_pkg::CntW;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  ftht_pkg::cmd_t cmd_i = '0;
  logic busy_o;
  logic done_o;
  ftht_pkg::rsp_t rsp_o;

  flow_tuple_hash_table_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #1 clk_i = ~clk_i;

  // shadow copy of the connection table
  logic            tbl_used [Slots];
  ftht_pkg::key_t  tbl_key  [Slots];
  logic [IdxW-1:0] tbl_home [Slots];
  int unsigned     tbl_count;

  ftht_pkg::rsp_t pending_rsp [$];
  ftht_pkg::key_t key_pool [$];
  int   mismatches;
  int   status_seen [4];
  int   max_count;

  function automatic logic [31:0] tuple_hash(ftht_pkg::key_t k);
    logic [31:0] h;
    h = ftht_pkg::FnvBasis;
    h = (h ^ k.saddr) * ftht_pkg::FnvPrime;
    h = (h ^ {16'd0, k.sport}) * ftht_pkg::FnvPrime;
    h = (h ^ k.daddr) * ftht_pkg::FnvPrime;
    h = (h ^ {16'd0, k.dport}) * ftht_pkg::FnvPrime;
    return h;
  endfunction

  // walk the probe chain; returns slot of the key or -1
  function automatic int find_slot(ftht_pkg::key_t k);
    int idx;
    idx = int'(tuple_hash(k) & (Slots - 1));
    for (int n = 0; n < Slots; n++) begin
      if (!tbl_used[idx]) return -1;
      if (tbl_key[idx] == k) return idx;
      idx = (idx + 1) % Slots;
    end
    return -1;
  endfunction

  // apply one command word to the shadow table and return its response
  function automatic ftht_pkg::rsp_t table_apply(ftht_pkg::cmd_t c);
    ftht_pkg::key_t k;
    ftht_pkg::rsp_t r;
    int idx, nxt, ri, home;
    ftht_pkg::key_t mk;
    logic [IdxW-1:0] mh;
    k = '{c.source_address, c.source_port, c.dest_address, c.dest_port};
    r.status = ftht_pkg::StNotFound;
    r.slot_index = '0;
    case (c.command)
      ftht_pkg::CmdInsert: begin
        if (tbl_count >= (Slots * 3) / 4) begin
          r.status = ftht_pkg::StFull;
        end else begin
          home = int'(tuple_hash(k) & (Slots - 1));
          idx = home;
          r.status = ftht_pkg::StFull;
          for (int n = 0; n < Slots; n++) begin
            if (!tbl_used[idx]) begin
              tbl_used[idx] = 1'b1;
              tbl_key[idx] = k;
              tbl_home[idx] = IdxW'(home);
              tbl_count++;
              r.status = ftht_pkg::StOk;
              r.slot_index = IdxW'(idx);
              break;
            end
            if (tbl_key[idx] == k) begin
              r.status = ftht_pkg::StDuplicate;
              break;
            end
            idx = (idx + 1) % Slots;
          end
        end
      end
      ftht_pkg::CmdLookup: begin
        idx = (tbl_count == 0) ? -1 : find_slot(k);
        if (idx >= 0) begin
          r.status = ftht_pkg::StOk;
          r.slot_index = IdxW'(idx);
        end
      end
      ftht_pkg::CmdRemove: begin
        idx = (tbl_count == 0) ? -1 : find_slot(k);
        if (idx >= 0) begin
          tbl_used[idx] = 1'b0;
          tbl_count--;
          // re-home the rest of the cluster
          nxt = (idx + 1) % Slots;
          for (int n = 0; n < Slots && tbl_used[nxt]; n++) begin
            mk = tbl_key[nxt];
            mh = tbl_home[nxt];
            ri = int'(mh);
            tbl_used[nxt] = 1'b0;
            for (int m = 0; m < Slots && tbl_used[ri]; m++) ri = (ri + 1) % Slots;
            tbl_used[ri] = 1'b1;
            tbl_key[ri] = mk;
            tbl_home[ri] = mh;
            nxt = (nxt + 1) % Slots;
          end
          r.status = ftht_pkg::StOk;
          r.slot_index = IdxW'(idx);
        end
      end
      default: ;
    endcase
    r.entry_count = CntW'(tbl_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // hand one word to the block; start_i stays high until the caller idles
  task automatic send_word(ftht_pkg::cmd_t c, bit typed, ftht_pkg::rsp_t typed_rsp);
    ftht_pkg::rsp_t r;
    ftht_pkg::key_t k;
    start_i <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy_o);
    r = table_apply(c);
    pending_rsp.push_back(typed ? typed_rsp : r);
    if (r.entry_count > max_count) max_count = r.entry_count;
    if (c.command == ftht_pkg::CmdInsert) begin
      k = '{c.source_address, c.source_port, c.dest_address, c.dest_port};
      key_pool.push_back(k);
    end
  endtask

  task automatic idle_gap();
    start_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  // response checker
  always @(posedge clk_i) begin
    ftht_pkg::rsp_t want;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected response words", 1, 0);
      end else begin
        want = pending_rsp.pop_front();
        status_seen[rsp_o.status]++;
        if (rsp_o.status !== want.status)
          report_mismatch("status", rsp_o.status, want.status);
        if (rsp_o.slot_index !== want.slot_index)
          report_mismatch("slot_index", rsp_o.slot_index, want.slot_index);
        if (rsp_o.entry_count !== want.entry_count)
          report_mismatch("entry_count", rsp_o.entry_count, want.entry_count);
      end
    end
  end

  typedef struct {
    ftht_pkg::cmd_t c;
    bit             typed;
    ftht_pkg::rsp_t r;
  } row_t;

  function automatic ftht_pkg::cmd_t mk_cmd(logic [1:0] op, ftht_pkg::key_t k);
    return '{op, k.saddr, k.sport, k.daddr, k.dport};
  endfunction

  function automatic ftht_pkg::key_t rand_key();
    return '{$urandom, 16'($urandom), $urandom, 16'($urandom)};
  endfunction

  initial begin
    row_t dir_rows [$];
    ftht_pkg::key_t k0, k1, km;
    ftht_pkg::cmd_t c;
    int   pick, ins_pct;
    k0 = '0;
    k1 = '1;
    km = '{32'hFFFF_FFFF, 16'h0000, 32'h0000_0000, 16'hFFFF};
    foreach (tbl_used[i]) tbl_used[i] = 1'b0;
    tbl_count = 0;

    // directed words: empty table, extremes, duplicate, unused code
    dir_rows = '{
      '{mk_cmd(ftht_pkg::CmdLookup, k0), 1, '{ftht_pkg::StNotFound, 10'd0, 11'd0}},
      '{mk_cmd(ftht_pkg::CmdRemove, k1), 1, '{ftht_pkg::StNotFound, 10'd0, 11'd0}},
      '{mk_cmd(2'd3, k1),                1, '{ftht_pkg::StNotFound, 10'd0, 11'd0}},
      '{mk_cmd(ftht_pkg::CmdInsert, k0), 0, '0},
      '{mk_cmd(ftht_pkg::CmdInsert, k1), 0, '0},
      '{mk_cmd(ftht_pkg::CmdInsert, k0), 1, '{ftht_pkg::StDuplicate, 10'd0, 11'd2}},
      '{mk_cmd(ftht_pkg::CmdLookup, k0), 0, '0},
      '{mk_cmd(ftht_pkg::CmdLookup, k1), 0, '0},
      '{mk_cmd(ftht_pkg::CmdLookup, km), 1, '{ftht_pkg::StNotFound, 10'd0, 11'd2}},
      '{mk_cmd(ftht_pkg::CmdInsert, km), 0, '0},
      '{mk_cmd(ftht_pkg::CmdRemove, k0), 0, '0},
      '{mk_cmd(ftht_pkg::CmdRemove, k0), 1, '{ftht_pkg::StNotFound, 10'd0, 11'd2}},
      '{mk_cmd(2'd3, k0),                1, '{ftht_pkg::StNotFound, 10'd0, 11'd2}},
      '{mk_cmd(ftht_pkg::CmdLookup, km), 0, '0},
      '{mk_cmd(ftht_pkg::CmdRemove, k1), 0, '0},
      '{mk_cmd(ftht_pkg::CmdRemove, km), 0, '0},
      '{mk_cmd(ftht_pkg::CmdLookup, k1), 1, '{ftht_pkg::StNotFound, 10'd0, 11'd0}}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);
      if ($urandom_range(0, 99) < 9) idle_gap();
    end

    // random words: fill past the full mark, then drain with removes
    for (int i = 0; i < RandWords; i++) begin
      ins_pct = (i < 1000) ? 92 : 25;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        c = mk_cmd(2'd3, rand_key());
      end else if (pick < 4 + ins_pct) begin
        // mostly fresh keys, some repeats to hit duplicates
        if (key_pool.size() > 0 && $urandom_range(0, 9) == 0)
          c = mk_cmd(ftht_pkg::CmdInsert,
                     key_pool[$urandom_range(0, key_pool.size() - 1)]);
        else
          c = mk_cmd(ftht_pkg::CmdInsert, rand_key());
      end else begin
        c = mk_cmd(($urandom_range(0, 2) == 0) ? ftht_pkg::CmdLookup : ftht_pkg::CmdRemove,
                   (key_pool.size() > 0 && $urandom_range(0, 9) < 8) ?
                   key_pool[$urandom_range(0, key_pool.size() - 1)] : rand_key());
      end
      send_word(c, 0, '0);
      if ((i < 300 || i >= 600) && $urandom_range(0, 99) < 9) idle_gap();
    end
    start_i <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("covered %0d ok, %0d not found, %0d duplicate, %0d full responses",
             status_seen[ftht_pkg::StOk], status_seen[ftht_pkg::StNotFound],
             status_seen[ftht_pkg::StDuplicate], status_seen[ftht_pkg::StFull]);
    $display("peak table load %0d of %0d slots, %0d mismatches", max_count, Slots, mismatches);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("flow_tuple_hash_table_core regression: pass");
    end else begin
      $display("flow_tuple_hash_table_core regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("timeout with %0d responses outstanding", pending_rsp.size());
    $display("flow_tuple_hash_table_core regression: fail");
    $finish;
  end

endmodule
